FILE: rtl/spm_pkg.sv
package spm_pkg;

    localparam int RADIUS_W = 16;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;

    localparam int OUT_W = 24;
    localparam int MAG_W = OUT_W + 1;
    localparam int RAD_ALIGN = 7;

    localparam logic [MAG_W-1:0] OUT_MAXPOS = 25'd8388607;
    localparam logic [MAG_W-1:0] OUT_MAXNEG = 25'd8388608;

    typedef struct packed {
        logic                    accepted;
        logic signed [OUT_W-1:0] coord_x;
        logic signed [OUT_W-1:0] coord_y;
        logic signed [OUT_W-1:0] coord_z;
    } t_result;

endpackage

FILE: rtl/sphere_point_marsaglia.sv
// Marsaglia sphere point picking, one attempt per input word.
// Input channel: i_valid/o_ready with two signed samples in [-1,1).
// Output channel: o_valid/i_ready with the accepted flag and the x, y and z
// coordinates in signed Q9.15; a rejected pair gives zero coordinates.
// Configuration channel: i_cfg_valid/o_cfg_ready writes the radius in
// unsigned Q8.8; it is always ready and should only be written while idle.
// One word is accepted every cycle while the output side keeps up.
// At the default width most of the pipeline from acceptance to o_valid is
// the square root pipeline, with one stage per result bit.
// The pipeline advances as a whole; a two-entry output buffer decouples
// o_ready from i_ready, so a stalled receiver holds the pipeline only once
// the second entry is full, and no word is lost or repeated.
// Reset clears all valid bits and loads the radius with 1.0.
module sphere_point_marsaglia
    import spm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [RADIUS_W-1:0]          i_cfg_radius,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_a,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_b,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_accepted,
    output logic signed [OUT_W-1:0]      o_coord_x,
    output logic signed [OUT_W-1:0]      o_coord_y,
    output logic signed [OUT_W-1:0]      o_coord_z
);

    localparam int SB   = SAMPLE_BITS;
    localparam int F    = SB - 1;
    localparam int SW   = 2 * SB;
    localparam int TW   = 2 * F;
    localparam int MW   = 2 * F + 1;
    localparam int LW   = F + 1;
    localparam int HW   = MW - LW;
    localparam int SUMW = RADIUS_W + MW;
    localparam int K_XY = 2 * F - 8;
    localparam int K_Z  = 2 * F - 7;

    localparam logic [SW-1:0] ONE_S  = SW'(1) << TW;
    localparam logic [SW:0]   ONE_S2 = (SW+1)'(1) << TW;

    typedef struct packed {
        logic          acc;
        logic          nu;
        logic          nv;
        logic          nz;
        logic [F-1:0]  mu;
        logic [F-1:0]  mv;
        logic [MW-1:0] mz;
    } t_side;

    function automatic logic [OUT_W-1:0] sat_coord(input logic neg,
                                                   input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] m;
        m = mag;
        if (neg) begin
            if (m > OUT_MAXNEG) begin
                m = OUT_MAXNEG;
            end
            return ~m[OUT_W-1:0] + 1'b1;
        end
        if (m > OUT_MAXPOS) begin
            m = OUT_MAXPOS;
        end
        return m[OUT_W-1:0];
    endfunction

    logic [RADIUS_W-1:0] r_radius;
    logic                w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_radius;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_ready     = w_en;

    // Stage 1: sign and magnitude.
    logic          r1_valid;
    logic [SB-1:0] r1_mu, r1_mv;
    logic          r1_nu, r1_nv;

    // Stage 2: squares.
    logic          r2_valid;
    logic [SW-1:0] r2_su, r2_sv;
    logic [SB-1:0] r2_mu, r2_mv;
    logic          r2_nu, r2_nv;

    // Stage 3: sum of squares.
    logic          r3_valid;
    logic [SW-1:0] r3_s;
    logic [SB-1:0] r3_mu, r3_mv;
    logic          r3_nu, r3_nv;

    // Stage 4: disc test, radicand and the z term.
    logic          r4_valid;
    logic [TW-1:0] r4_t;
    t_side         r4_side;

    logic [SW-1:0] w_t_full;
    logic [SW:0]   w_two_s;
    logic [SW:0]   w_mz_up;
    logic [SW:0]   w_mz_dn;
    logic          w_nz;

    assign w_t_full = ONE_S - r3_s;
    assign w_two_s  = {r3_s, 1'b0};
    assign w_mz_up  = w_two_s - ONE_S2;
    assign w_mz_dn  = ONE_S2 - w_two_s;
    assign w_nz     = (w_two_s > ONE_S2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_nu <= i_sample_a[SB-1];
            r1_nv <= i_sample_b[SB-1];
            r1_mu <= i_sample_a[SB-1] ? (~i_sample_a + 1'b1) : i_sample_a;
            r1_mv <= i_sample_b[SB-1] ? (~i_sample_b + 1'b1) : i_sample_b;

            r2_su <= SW'(r1_mu) * SW'(r1_mu);
            r2_sv <= SW'(r1_mv) * SW'(r1_mv);
            r2_mu <= r1_mu;
            r2_mv <= r1_mv;
            r2_nu <= r1_nu;
            r2_nv <= r1_nv;

            r3_s  <= r2_su + r2_sv;
            r3_mu <= r2_mu;
            r3_mv <= r2_mv;
            r3_nu <= r2_nu;
            r3_nv <= r2_nv;

            r4_t         <= w_t_full[TW-1:0];
            r4_side.acc  <= (r3_s < ONE_S);
            r4_side.nu   <= r3_nu;
            r4_side.nv   <= r3_nv;
            r4_side.nz   <= w_nz;
            r4_side.mu   <= r3_mu[F-1:0];
            r4_side.mv   <= r3_mv[F-1:0];
            r4_side.mz   <= w_nz ? w_mz_up[MW-1:0] : w_mz_dn[MW-1:0];
        end
    end

    logic                  w_sq_valid;
    logic [F-1:0]          w_sq_root;
    logic [$bits(t_side)-1:0] w_sq_side_raw;
    t_side                 w_sq_side;

    spm_sqrt_pipe #(
        .ROOT_W (F),
        .SIDE_W ($bits(t_side))
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r4_valid),
        .i_radicand (r4_t),
        .i_side     (r4_side),
        .o_valid    (w_sq_valid),
        .o_root     (w_sq_root),
        .o_side     (w_sq_side_raw)
    );

    assign w_sq_side = t_side'(w_sq_side_raw);

    // Stage 5: sample times root.
    logic          r5_valid;
    logic [TW-1:0] r5_px, r5_py;
    logic [MW-1:0] r5_mz;
    logic          r5_acc, r5_nu, r5_nv, r5_nz;

    // Stage 6: radius times low and high halves.
    logic                     r6_valid;
    logic [RADIUS_W+LW-1:0]   r6_xlo, r6_ylo, r6_zlo;
    logic [RADIUS_W+HW-1:0]   r6_xhi, r6_yhi, r6_zhi;
    logic                     r6_acc, r6_nu, r6_nv, r6_nz;

    // Stage 7: recombine and align to 15 fraction bits.
    logic             r7_valid;
    logic [MAG_W-1:0] r7_mx, r7_my, r7_mz;
    logic             r7_acc, r7_nu, r7_nv, r7_nz;

    // Stage 8: sign and saturation.
    logic    r8_valid;
    t_result r8_res;

    logic [MW-1:0]   w_px_ext, w_py_ext;
    logic [SUMW-1:0] w_sum_x, w_sum_y, w_sum_z;

    assign w_px_ext = MW'(r5_px);
    assign w_py_ext = MW'(r5_py);
    assign w_sum_x  = {r6_xhi, {LW{1'b0}}} + SUMW'(r6_xlo);
    assign w_sum_y  = {r6_yhi, {LW{1'b0}}} + SUMW'(r6_ylo);
    assign w_sum_z  = {r6_zhi, {LW{1'b0}}} + SUMW'(r6_zlo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
        end else if (w_en) begin
            r5_valid <= w_sq_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
            r8_valid <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_px  <= TW'(w_sq_side.mu) * TW'(w_sq_root);
            r5_py  <= TW'(w_sq_side.mv) * TW'(w_sq_root);
            r5_mz  <= w_sq_side.mz;
            r5_acc <= w_sq_side.acc;
            r5_nu  <= w_sq_side.nu;
            r5_nv  <= w_sq_side.nv;
            r5_nz  <= w_sq_side.nz;

            r6_xlo <= (RADIUS_W+LW)'(r_radius) * (RADIUS_W+LW)'(w_px_ext[LW-1:0]);
            r6_ylo <= (RADIUS_W+LW)'(r_radius) * (RADIUS_W+LW)'(w_py_ext[LW-1:0]);
            r6_zlo <= (RADIUS_W+LW)'(r_radius) * (RADIUS_W+LW)'(r5_mz[LW-1:0]);
            r6_xhi <= (RADIUS_W+HW)'(r_radius) * (RADIUS_W+HW)'(w_px_ext[MW-1:LW]);
            r6_yhi <= (RADIUS_W+HW)'(r_radius) * (RADIUS_W+HW)'(w_py_ext[MW-1:LW]);
            r6_zhi <= (RADIUS_W+HW)'(r_radius) * (RADIUS_W+HW)'(r5_mz[MW-1:LW]);
            r6_acc <= r5_acc;
            r6_nu  <= r5_nu;
            r6_nv  <= r5_nv;
            r6_nz  <= r5_nz;

            r7_mx  <= w_sum_x[K_XY +: MAG_W];
            r7_my  <= w_sum_y[K_XY +: MAG_W];
            r7_mz  <= MAG_W'(w_sum_z[K_Z +: OUT_W]);
            r7_acc <= r6_acc;
            r7_nu  <= r6_nu;
            r7_nv  <= r6_nv;
            r7_nz  <= r6_nz;

            r8_res.accepted <= r7_acc;
            r8_res.coord_x  <= r7_acc ? sat_coord(r7_nu, r7_mx) : '0;
            r8_res.coord_y  <= r7_acc ? sat_coord(r7_nv, r7_my) : '0;
            r8_res.coord_z  <= r7_acc ? sat_coord(r7_nz, r7_mz) : '0;
        end
    end

    t_result w_out;

    spm_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r8_valid),
        .i_data     (r8_res),
        .o_in_ready (w_en),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (w_out)
    );

    assign o_accepted = w_out.accepted;
    assign o_coord_x  = w_out.coord_x;
    assign o_coord_y  = w_out.coord_y;
    assign o_coord_z  = w_out.coord_z;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |->
            o_coord_x == '0 && o_coord_y == '0 && o_coord_z == '0)
        else $error("rejected word carries nonzero coordinates");

    a_z_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |->
            $signed(o_coord_z) <= $signed({1'b0, r_radius, {RAD_ALIGN{1'b0}}}) &&
            $signed(o_coord_z) >= -$signed({1'b0, r_radius, {RAD_ALIGN{1'b0}}}))
        else $error("z coordinate outside the radius");

    a_x_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |->
            $signed(o_coord_x) <= $signed({1'b0, r_radius, {RAD_ALIGN{1'b0}}}) &&
            $signed(o_coord_x) >= -$signed({1'b0, r_radius, {RAD_ALIGN{1'b0}}}))
        else $error("x coordinate outside the radius");
`endif

endmodule

FILE: rtl/spm_sqrt_pipe.sv
module spm_sqrt_pipe
    import spm_pkg::*;
#(
    parameter int ROOT_W = 15,
    parameter int SIDE_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2*ROOT_W-1:0]   i_radicand,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic [ROOT_W-1:0]              c_valid;
    logic [ROOT_W-1:0][REM_W-1:0]   c_rem;
    logic [ROOT_W-1:0][ROOT_W-1:0]  c_root;
    logic [ROOT_W-1:0][RAD_W-1:0]   c_rad;
    logic [ROOT_W-1:0][SIDE_W-1:0]  c_side;

    logic [ROOT_W-1:0]              r_valid;
    logic [ROOT_W-1:0][REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0][ROOT_W-1:0]  r_root;
    logic [ROOT_W-1:0][RAD_W-1:0]   r_rad;
    logic [ROOT_W-1:0][SIDE_W-1:0]  r_side;

    // One result bit per stage, most significant first: two radicand bits
    // are brought down and a trial subtraction decides the bit.
    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [REM_W-1:0]  w_shifted;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (g == 0) begin : g_first
            assign c_valid[g] = i_valid;
            assign c_rem[g]   = '0;
            assign c_root[g]  = '0;
            assign c_rad[g]   = i_radicand;
            assign c_side[g]  = i_side;
        end else begin : g_next
            assign c_valid[g] = r_valid[g-1];
            assign c_rem[g]   = r_rem[g-1];
            assign c_root[g]  = r_root[g-1];
            assign c_rad[g]   = r_rad[g-1];
            assign c_side[g]  = r_side[g-1];
        end

        assign w_shifted = {c_rem[g][REM_W-3:0], c_rad[g][2*(ROOT_W-1-g) +: 2]};
        assign w_trial   = REM_W'({c_root[g], 2'b01});
        assign w_ge      = (w_shifted >= w_trial);
        assign n_rem     = w_ge ? (w_shifted - w_trial) : w_shifted;
        assign n_root    = {c_root[g][ROOT_W-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= c_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_rad[g]  <= c_rad[g];
                r_side[g] <= c_side[g];
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

FILE: rtl/spm_out_buf.sv
module spm_out_buf
    import spm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_in_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    logic    w_in_fire;
    logic    w_out_free;
    logic    n_out_valid;
    logic    n_skid_valid;

    assign w_in_fire  = i_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_out_free) begin
            n_out_valid  = r_skid_valid || w_in_fire;
            n_skid_valid = 1'b0;
        end else if (w_in_fire) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (w_in_fire) begin
            r_skid <= i_data;
        end
    end

    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

endmodule

FILE: dv/tb.sv
module tb
    import spm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = 16;
    localparam int FRAC = SAMPLE_W - 1;
    localparam int PROD_SHIFT = 2 * FRAC - RAD_ALIGN;
    localparam longint unsigned UNIT = 64'd1 << (2 * FRAC);
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 234;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOW_LIMIT = 10;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_EVERY_THIRD,
        RX_LONG_STALL
    } rx_mode_e;

    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [RADIUS_W-1:0]           i_cfg_radius = '0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic signed [SAMPLE_W-1:0]    i_sample_a = '0;
    logic signed [SAMPLE_W-1:0]    i_sample_b = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic                          o_accepted;
    logic signed [OUT_W-1:0]       o_coord_x;
    logic signed [OUT_W-1:0]       o_coord_y;
    logic signed [OUT_W-1:0]       o_coord_z;

    sphere_point_marsaglia #(
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_radius(i_cfg_radius),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample_a  (i_sample_a),
        .i_sample_b  (i_sample_b),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_accepted  (o_accepted),
        .o_coord_x   (o_coord_x),
        .o_coord_y   (o_coord_y),
        .o_coord_z   (o_coord_z)
    );

    function automatic longint unsigned sqrt_floor(longint unsigned t);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = FRAC; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= t) begin
                root = cand;
            end
        end
        return root;
    endfunction

    class point_checker;
        longint unsigned radius;
        t_result         expected_points[$];
        int unsigned     failures;
        int unsigned     points_checked;
        int unsigned     inside_count;
        int unsigned     rejected_count;

        function new();
            radius = RADIUS_RESET;
        endfunction

        function void set_radius(logic [RADIUS_W-1:0] r);
            radius = r;
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        function logic signed [OUT_W-1:0] to_q9_15(bit neg, longint unsigned mag);
            longint unsigned wrapped;
            if (neg) begin
                if (mag > OUT_MAXNEG) begin
                    mag = OUT_MAXNEG;
                end
                wrapped = 64'd0 - mag;
                return wrapped[OUT_W-1:0];
            end
            if (mag > OUT_MAXPOS) begin
                mag = OUT_MAXPOS;
            end
            return mag[OUT_W-1:0];
        endfunction

        function t_result predict_point(logic signed [SAMPLE_W-1:0] a,
                                        logic signed [SAMPLE_W-1:0] b);
            longint          sa;
            longint          sb;
            longint unsigned mu;
            longint unsigned mv;
            longint unsigned s;
            longint unsigned q;
            longint unsigned mz;
            bit              nz;
            t_result         r;
            sa = a;
            sb = b;
            mu = (sa < 0) ? -sa : sa;
            mv = (sb < 0) ? -sb : sb;
            s = mu * mu + mv * mv;
            r = '0;
            if (s >= UNIT) begin
                rejected_count++;
                return r;
            end
            inside_count++;
            q = sqrt_floor(UNIT - s);
            nz = (2 * s > UNIT);
            mz = nz ? 2 * s - UNIT : UNIT - 2 * s;
            r.accepted = 1'b1;
            r.coord_x = to_q9_15(sa < 0, (radius * 2 * mu * q) >> PROD_SHIFT);
            r.coord_y = to_q9_15(sb < 0, (radius * 2 * mv * q) >> PROD_SHIFT);
            r.coord_z = to_q9_15(nz, (radius * mz) >> PROD_SHIFT);
            return r;
        endfunction

        function void note_pair(logic signed [SAMPLE_W-1:0] a,
                                logic signed [SAMPLE_W-1:0] b);
            expected_points.push_back(predict_point(a, b));
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_points.size() == 0) begin
                failures++;
                if (failures <= SHOW_LIMIT) begin
                    $display("Unexpected point: accepted=%0b x=%0d y=%0d z=%0d",
                             got.accepted, got.coord_x, got.coord_y, got.coord_z);
                end
                return;
            end
            want = expected_points.pop_front();
            points_checked++;
            if (got.accepted !== want.accepted || got.coord_x !== want.coord_x
                    || got.coord_y !== want.coord_y || got.coord_z !== want.coord_z) begin
                failures++;
                if (failures <= SHOW_LIMIT) begin
                    $display("Point %0d mismatch: expected accepted=%0b x=%0d y=%0d z=%0d",
                             points_checked, want.accepted, want.coord_x, want.coord_y,
                             want.coord_z);
                    $display("    got accepted=%0b x=%0d y=%0d z=%0d",
                             got.accepted, got.coord_x, got.coord_y, got.coord_z);
                end
            end
        endfunction

        function void close_out();
            if (expected_points.size() != 0) begin
                $display("%0d expected points never arrived.", expected_points.size());
                failures += expected_points.size();
            end
        endfunction
    endclass

    point_checker board;
    int unsigned  cycle_count = 0;
    int unsigned  burst_left = 0;
    int unsigned  rx_tick = 0;
    rx_mode_e     rx_mode = RX_STEADY;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles without finishing.", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 64 == 0) begin
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_STEADY: begin
                i_ready <= 1'b1;
            end
            RX_COIN: begin
                i_ready <= ($urandom_range(0, 1) == 1);
            end
            RX_EVERY_THIRD: begin
                i_ready <= (rx_tick % 3 != 0);
            end
            default: begin
                i_ready <= (rx_tick[4:3] == 2'd0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_result('{o_accepted, o_coord_x, o_coord_y, o_coord_z});
        end
    end

    function automatic int unsigned next_idle();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 31);
        if ($urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(1, 8);
    endfunction

    task automatic send_pair(input logic signed [SAMPLE_W-1:0] a,
                             input logic signed [SAMPLE_W-1:0] b);
        int unsigned idle;
        idle = next_idle();
        if (idle > 0) begin
            i_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_a <= a;
        i_sample_b <= b;
        do @(posedge i_clk); while (!o_ready);
        board.note_pair(a, b);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] r);
        i_cfg_valid <= 1'b1;
        i_cfg_radius <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.set_radius(r);
    endtask

    task automatic random_pair(output logic signed [SAMPLE_W-1:0] a,
                               output logic signed [SAMPLE_W-1:0] b);
        int          pick;
        int          u;
        int          v;
        int          tmp;
        int          extremes[8];
        longint      w;
        extremes = '{0, 1, -1, 32767, -32768, -32767, 16384, -16384};
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            a = SAMPLE_W'($urandom());
            b = SAMPLE_W'($urandom());
        end else if (pick < 85) begin
            // Pairs straddling the edge of the unit disc.
            u = $urandom_range(0, 32767);
            w = sqrt_floor(UNIT - longint'(u) * u);
            v = int'(w) + $urandom_range(0, 2) - 1;
            if (v < 0) begin
                v = 0;
            end
            if (v > 32768) begin
                v = 32768;
            end
            if ($urandom_range(0, 1) == 1) begin
                u = -u;
            end
            if ($urandom_range(0, 1) == 1) begin
                v = -v;
            end else if (v > 32767) begin
                v = 32767;
            end
            if ($urandom_range(0, 1) == 1) begin
                tmp = u;
                u = v;
                v = tmp;
            end
            a = SAMPLE_W'(u);
            b = SAMPLE_W'(v);
        end else if (pick < 93) begin
            u = $urandom_range(0, 255);
            v = $urandom_range(0, 255);
            a = SAMPLE_W'(($urandom_range(0, 1) == 1) ? -u : u);
            b = SAMPLE_W'(($urandom_range(0, 1) == 1) ? -v : v);
        end else begin
            a = SAMPLE_W'(extremes[$urandom_range(0, 7)]);
            b = SAMPLE_W'(extremes[$urandom_range(0, 7)]);
        end
    endtask

    initial begin
        int                         directed_pairs[20][2];
        logic [RADIUS_W-1:0]        phase_radius[PHASES];
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        int unsigned                sent;
        directed_pairs = '{
            '{0, 0}, '{1, 0}, '{0, -1}, '{-1, -1}, '{32767, 0}, '{0, 32767},
            '{-32767, 0}, '{-32768, 0}, '{0, -32768}, '{-32768, -32768},
            '{32767, 32767}, '{-32768, 32767}, '{16384, 16384}, '{-16384, 16384},
            '{23170, 23170}, '{23170, -23171}, '{-23171, -23171}, '{32767, 1},
            '{181, -32767}, '{21845, -10923}
        };
        phase_radius = '{16'hFFFF, 16'd0, 16'd1, 16'($urandom()), 16'd128,
                         16'($urandom()), RADIUS_RESET};
        sent = 0;
        board = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_pairs[n]) begin
            send_pair(SAMPLE_W'(directed_pairs[n][0]), SAMPLE_W'(directed_pairs[n][1]));
            sent++;
        end
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            write_radius(phase_radius[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                random_pair(a, b);
                send_pair(a, b);
                sent++;
                if (p == 0 && i == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        board.close_out();
        $display("Sent %0d sample pairs: %0d inside the unit disc, %0d rejected.",
                 sent, board.inside_count, board.rejected_count);
        $display("Radius took %0d settings, from zero to full scale.", PHASES + 1);
        if (board.failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
